// ----- hw/rtl/sample_history_window_ac_power_assert.svh -----
// assertion macros for the sample history window rtl
// no dependencies; included by sample_history_window_ac_power, which checks its own logic
`ifndef SAMPLE_HISTORY_WINDOW_AC_POWER_ASSERT_SVH
`define SAMPLE_HISTORY_WINDOW_AC_POWER_ASSERT_SVH

// same-cycle implication
`define SHWAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHWAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication with a delayed consequent
`define SHWAC_ASSERT_DLY2(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/shwac_pkg.sv -----
// shared types and codes for the sample history window block
// no dependencies; used by shwac_div and sample_history_window_ac_power
`default_nettype none

package shwac_pkg;

    typedef enum logic [1:0] {
        REQ_STORE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_POWER   = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_POWER = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_OUT_RANGE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/shwac_div.sv -----
// divider by a fixed divisor: multiply by its rounded-up reciprocal, one 16-bit slice a cycle
// depends on shwac_pkg for the status struct
`default_nettype none

module shwac_div #(
    parameter int WIDTH   = 33,
    parameter int DIVISOR = 400
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [WIDTH-1:0]      i_dividend,
    output shwac_pkg::t_div_stat       o_stat,
    output logic      [WIDTH-1:0]      o_quotient
);
    import shwac_pkg::*;

    // floor(x / d) equals (x * ceil(2**SH / d)) >> SH for every x below 2**WIDTH
    localparam int SH  = WIDTH + $clog2(DIVISOR);
    localparam int SL  = 16;
    localparam int NSL = (WIDTH + 1 + SL - 1) / SL;
    localparam int MPW = NSL * SL;
    localparam int AW  = WIDTH + MPW;
    localparam int KW  = $clog2(NSL + 1);
    localparam logic [MPW-1:0] RECIP =
        MPW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic             r_busy;
    logic             r_done;
    logic [KW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_x;
    logic [MPW-1:0]   r_m;
    logic [AW-1:0]    r_acc;

    logic [WIDTH+SL-1:0] slice_prod;

    assign slice_prod = (WIDTH + SL)'(r_x) * (WIDTH + SL)'(r_m[MPW-1 -: SL]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_dividend;
                r_m    <= RECIP;
                r_acc  <= '0;
            end else if (r_busy) begin
                // top slice of the reciprocal first
                r_acc <= {r_acc[AW-SL-1:0], {SL{1'b0}}} + AW'(slice_prod);
                r_m   <= {r_m[MPW-SL-1:0], {SL{1'b0}}};
                if (r_cnt == KW'(NSL - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = WIDTH'(r_acc >> SH);

endmodule

`default_nettype wire

// ----- hw/rtl/sample_history_window_ac_power.sv -----
// Sample history window with read-back and windowed ac power.
// Command port: an item is taken at a rising edge with i_start high and
// o_busy low. Fields: i_req_type (store, read back, power, restart),
// i_sample_value, i_lookback.
// Store and restart leave o_busy low, so a sample can be taken every cycle.
// They give no result.
// Read back: o_busy is high for one cycle, and the result strobe o_valid
// rises in the same cycle that o_busy falls. A lookback at or above CAPACITY
// gives o_status high and a zero value.
// Power: two walks of WINDOW samples through the sample memory (one read
// port, one sample a cycle), each followed by a divide by WINDOW done as a
// multiply by its reciprocal, one 16-bit slice a cycle; o_valid rises in
// the same cycle that o_busy falls.
// o_valid is high for exactly one cycle with the result on the output ports;
// the receiver cannot hold it off, and o_busy is low in that cycle.
// Reset (and a restart item) empties the history at once: a fill position
// and a wrapped flag mark which memory entries were written, and unwritten
// entries read as zero, so no clearing pass is needed.
// Depends on shwac_pkg, shwac_div and the assertion macro header.
`default_nettype none

`include "sample_history_window_ac_power_assert.svh"

module sample_history_window_ac_power #(
    parameter int CAPACITY    = 512,
    parameter int WINDOW      = 400,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_sample_value,
    input  wire logic [9:0]  i_lookback,
    output logic             o_valid,
    output logic             o_result_kind,
    output logic [11:0]      o_read_value,
    output logic [31:0]      o_window_power,
    output logic             o_status
);
    import shwac_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(WINDOW);
    localparam int ACCW = 2 * SAMPLE_BITS + $clog2(WINDOW + 1);
    localparam int QW   = 2 * SAMPLE_BITS;
    localparam int WOFF = WINDOW % CAPACITY;
    localparam int HALF = CAPACITY / 2;
    localparam int SW   = ((IW > 10) ? IW : 10) + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_WALK,
        S_DRAIN,
        S_DIV
    } t_state;

    t_state                 r_state;
    logic                   r_pass;
    logic [IW-1:0]          r_fill;
    logic                   r_wrapped;
    logic                   r_vis_hi;
    logic [IW-1:0]          r_pos;
    logic [CW-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0] r_mem [CAPACITY];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_p1_vld;
    logic                   r_p1_ok;
    logic                   r_rb_ok;
    logic                   r_rb_status;
    logic [QW-1:0]          r_sq;
    logic                   r_sq_vld;
    logic [ACCW-1:0]        r_acc;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic                   r_div_start;

    logic                   accept;
    t_req                   req;
    logic [IW-1:0]          vis;
    logic [IW-1:0]          fill_inc;
    logic [IW-1:0]          pos_inc;
    logic [SW-1:0]          back_diff;
    logic [IW-1:0]          src_addr;
    logic                   in_range;
    logic [IW:0]            vis_ext;
    logic [IW-1:0]          walk_start;
    logic [IW-1:0]          rd_addr;
    logic                   mem_we;
    logic [SAMPLE_BITS-1:0] cur_val;
    logic [SAMPLE_BITS-1:0] dev;
    t_div_stat              div_stat;
    logic [ACCW-1:0]        div_quo;

    assign accept   = i_start && !o_busy;
    assign req      = t_req'(i_req_type);
    assign o_busy   = (r_state != S_IDLE);
    assign vis      = r_vis_hi ? IW'(HALF) : '0;
    assign fill_inc = (r_fill == IW'(CAPACITY - 1)) ? '0 : (r_fill + 1'b1);
    assign pos_inc  = (r_pos == IW'(CAPACITY - 1)) ? '0 : (r_pos + 1'b1);

    // newest visible sample sits one slot before the visible index
    assign back_diff = SW'(vis) - SW'(1) - SW'(i_lookback);
    assign src_addr  = back_diff[SW-1] ? IW'(back_diff + SW'(CAPACITY)) : IW'(back_diff);
    assign in_range  = (int'(i_lookback) < CAPACITY);

    assign vis_ext    = {1'b0, vis};
    assign walk_start = (vis_ext >= (IW + 1)'(WOFF)) ? IW'(vis_ext - (IW + 1)'(WOFF))
                                                      : IW'(vis_ext + (IW + 1)'(CAPACITY - WOFF));

    assign rd_addr = (r_state == S_WALK) ? r_pos : src_addr;
    assign mem_we  = accept && (req == REQ_STORE);

    assign cur_val = r_p1_ok ? r_rd_data : '0;
    assign dev     = (cur_val >= r_mean) ? (cur_val - r_mean) : (r_mean - cur_val);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= SAMPLE_BITS'(i_sample_value);
        end
        r_rd_data <= r_mem[rd_addr];
    end

    shwac_div #(
        .WIDTH   (ACCW),
        .DIVISOR (WINDOW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            r_fill      <= '0;
            r_wrapped   <= 1'b0;
            r_vis_hi    <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_sq_vld    <= 1'b0;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid     <= 1'b0;
            r_div_start <= 1'b0;

            // walk pipeline: memory read, square (second pass only), accumulate
            r_p1_vld <= (r_state == S_WALK);
            r_p1_ok  <= r_wrapped || (r_pos < r_fill);
            r_sq     <= QW'(dev) * QW'(dev);
            r_sq_vld <= r_p1_vld && r_pass;
            if (r_p1_vld && !r_pass) begin
                r_acc <= r_acc + ACCW'(cur_val);
            end else if (r_sq_vld) begin
                r_acc <= r_acc + ACCW'(r_sq);
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (req)
                            REQ_STORE: begin
                                r_fill <= fill_inc;
                                if (fill_inc == IW'(HALF)) begin
                                    r_vis_hi <= 1'b1;
                                end else if (fill_inc == '0) begin
                                    r_vis_hi  <= 1'b0;
                                    r_wrapped <= 1'b1;
                                end
                            end
                            REQ_READ: begin
                                r_rb_status <= in_range ? STATUS_OK : STATUS_OUT_RANGE;
                                r_rb_ok     <= in_range && (r_wrapped || (src_addr < r_fill));
                                r_state     <= S_RD_WAIT;
                            end
                            REQ_POWER: begin
                                r_pass  <= 1'b0;
                                r_pos   <= walk_start;
                                r_cnt   <= '0;
                                r_acc   <= '0;
                                r_state <= S_WALK;
                            end
                            REQ_RESTART: begin
                                r_fill    <= '0;
                                r_wrapped <= 1'b0;
                                r_vis_hi  <= 1'b0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    o_valid        <= 1'b1;
                    o_result_kind  <= KIND_READ;
                    o_read_value   <= r_rb_ok ? 12'(r_rd_data) : '0;
                    o_window_power <= '0;
                    o_status       <= r_rb_status;
                    r_state        <= S_IDLE;
                end
                S_WALK: begin
                    r_pos <= pos_inc;
                    if (r_cnt == CW'(WINDOW - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_vld && !r_sq_vld) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (!r_pass) begin
                            r_mean  <= SAMPLE_BITS'(div_quo);
                            r_pass  <= 1'b1;
                            r_pos   <= walk_start;
                            r_cnt   <= '0;
                            r_acc   <= '0;
                            r_state <= S_WALK;
                        end else begin
                            o_valid        <= 1'b1;
                            o_result_kind  <= KIND_POWER;
                            o_read_value   <= '0;
                            o_window_power <= 32'(div_quo[QW-1:0]);
                            o_status       <= STATUS_OK;
                            r_state        <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SHWAC_ASSERT_NOW(a_valid_not_busy, i_clk, i_rst_n,
        o_valid, !o_busy, "result strobe while busy")
    `SHWAC_ASSERT_NEXT(a_store_no_stall, i_clk, i_rst_n,
        accept && (req == REQ_STORE || req == REQ_RESTART), !o_busy,
        "store or restart item stalled the port")
    `SHWAC_ASSERT_DLY2(a_read_latency, i_clk, i_rst_n,
        accept && req == REQ_READ, o_valid && o_result_kind == KIND_READ,
        "read-back result missing two cycles after accept")
    `SHWAC_ASSERT_NOW(a_power_fields, i_clk, i_rst_n,
        o_valid && o_result_kind == KIND_POWER,
        o_status == STATUS_OK && o_read_value == 12'd0,
        "power result carries read-back fields")
    `SHWAC_ASSERT_NOW(a_range_zero, i_clk, i_rst_n,
        o_valid && o_status == STATUS_OUT_RANGE,
        o_read_value == 12'd0 && o_result_kind == KIND_READ,
        "out of range read-back returned data")

endmodule

`default_nettype wire
